@@ sv/incremental_region_perimeter_defines.svh @@
// Assertion macros shared by the incremental region perimeter RTL.
`ifndef INCREMENTAL_REGION_PERIMETER_DEFINES_SVH
`define INCREMENTAL_REGION_PERIMETER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define IRP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define IRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/irp_pkg.sv @@
// Package with constants and codes of the incremental region perimeter block.
`timescale 1ns / 1ps
`default_nettype none
package irp_pkg;

   // Default map size
   localparam int IRP_MAX_WIDTH  = 256;
   localparam int IRP_MAX_HEIGHT = 256;

   // Item kinds carried in tuser
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_MARK = 2'd1;
   localparam logic [1:0] FUNC_ADD  = 2'd2;

   // Register index, taken from paddr bit 2
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // Register reset values
   localparam logic [8:0] IMAGE_SIZE_RESET = 9'd256;

   // Perimeter saturation limits
   localparam logic [23:0] PER_MAX = 24'h7FFFFF;
   localparam logic [23:0] PER_MIN = 24'h800000;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_BUSY  = 3'b100
   } state_type;

endpackage
`default_nettype wire

@@ sv/incremental_region_perimeter.sv @@
// Top level of the incremental region perimeter block.
`timescale 1ns / 1ps
`default_nettype none
`include "incremental_region_perimeter_defines.svh"
// Keeps a one-bit membership map of up to MAX_WIDTH x MAX_HEIGHT pixels and a
// running 24-bit signed perimeter. tuser selects the item kind: load sets the
// perimeter to start_value, mark sets a pixel bit, add counts the set
// 4-neighbours q, adds 4-2q with saturation and sets the bit; every item
// returns one beat with the perimeter and q. The map is held as rows, split
// into an even-row and an odd-row bank, so the center row and the rows above
// and below are read in the same cycle. An item is worked first by the row
// reads as it is accepted, then by a busy state that counts, updates the
// perimeter, sets the bit and loads the result register; the busy state
// stretches while an earlier result beat still waits on rsp_tready. The next
// item's reads follow that write. After reset a clearing pass zeroes one row
// pair per cycle through every row-pair address with req_tready low; register
// writes are taken throughout. Pixels outside the configured image are ignored.
module incremental_region_perimeter
   import irp_pkg::*;
#(
   parameter int MAX_WIDTH  = IRP_MAX_WIDTH,
   parameter int MAX_HEIGHT = IRP_MAX_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Item channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] pixel_x, [15:8] pixel_y, [39:16] start_value
   input  wire logic [39:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]  req_tuser,
   // Result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [23:0] perimeter, [26:24] set_neighbours, [31:27] zero
   output logic      [31:0] rsp_tdata,
   // Register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WORD_W = 2 ** XW;
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int BA_W  = (ROW_W > 1) ? ROW_W - 1 : 1;
   localparam int CX    = (XW > 9) ? XW : 9;
   localparam int CY    = (BA_W + 1 > 9) ? BA_W + 1 : 9;
   localparam int LW_X  = $clog2(MAX_WIDTH + 1);
   localparam int LW_Y  = $clog2(MAX_HEIGHT + 1);
   localparam int EX    = (LW_X > CX) ? LW_X : CX;
   localparam int EY    = (LW_Y > CY) ? LW_Y : CY;

   // Control and configuration registers
   state_type         state_ff, state_in;
   logic [BA_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [8:0]        width_ff, width_in;
   logic [8:0]        height_ff, height_in;
   logic [23:0]       per_ff, per_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_per_ff, rsp_per_in;
   logic [2:0]        rsp_q_ff, rsp_q_in;

   // Captured item
   logic [1:0]        func_ff;
   logic [7:0]        x_ff;
   logic [7:0]        y_ff;
   logic [23:0]       start_ff;

   logic              accept;
   logic              rsp_load;
   logic              csr_wr;

   // Request address decode
   logic [7:0]        req_y;
   logic [CY-1:0]     a_yc, a_yu, a_yd;
   logic [BA_W-1:0]   c_addr, u_addr, d_addr;
   logic [BA_W-1:0]   bank_addr0 [2];

   // Bank ports
   logic [WORD_W-1:0] bank_rd0 [2];
   logic [WORD_W-1:0] bank_rd1 [2];
   logic              bank_set [2];
   logic              clr_en;
   logic [CY-1:0]     w_yc;
   logic [BA_W-1:0]   wr_addr;

   // Neighbour evaluation
   logic [WORD_W-1:0] row_c, row_u, row_d;
   logic [CX-1:0]     xc, xl, xr;
   logic [CY-1:0]     yc, yd;
   logic [EX-1:0]     eff_w;
   logic [EY-1:0]     eff_h;
   logic              in_img, do_add, do_set;
   logic              has_l, has_t, has_r, has_b;
   logic              bit_l, bit_t, bit_r, bit_b;
   logic [2:0]        q;
   logic [3:0]        delta;
   logic [24:0]       sum;
   logic [23:0]       sat;

   assign accept   = req_tvalid && req_tready;
   assign rsp_load = (state_ff == ST_BUSY) && (!rsp_valid_ff || rsp_tready);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Sequencer: clear pass, then idle/busy per item
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + BA_W'(1);
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign clr_en     = (state_ff == ST_CLEAR);

   // Row addresses of the accepted item: center, above, below
   assign req_y  = req_tdata[15:8];
   assign a_yc   = CY'(req_y);
   assign a_yu   = a_yc - CY'(1);
   assign a_yd   = a_yc + CY'(1);
   assign c_addr = a_yc[BA_W:1];
   assign u_addr = a_yu[BA_W:1];
   assign d_addr = a_yd[BA_W:1];

   // Center row in its parity bank, neighbour rows both in the other one
   assign bank_addr0[0] = req_y[0] ? u_addr : c_addr;
   assign bank_addr0[1] = req_y[0] ? c_addr : u_addr;

   assign w_yc    = CY'(y_ff);
   assign wr_addr = clr_en ? clr_cnt_ff : w_yc[BA_W:1];

   for (genvar b = 0; b < 2; b++) begin : g_bank
      assign bank_set[b] = rsp_load && do_set && (y_ff[0] == 1'(b));

      irp_row_bank #(
         .WORD_W (WORD_W),
         .ADDR_W (BA_W)
      ) u_bank (
         .clock    (clock),
         .rd_en    (accept),
         .rd_addr0 (bank_addr0[b]),
         .rd_addr1 (d_addr),
         .rd_data0 (bank_rd0[b]),
         .rd_data1 (bank_rd1[b]),
         .clr_en   (clr_en),
         .set_en   (bank_set[b]),
         .wr_addr  (wr_addr),
         .wr_bit   (xc[XW-1:0])
      );
   end

   // Steer bank data back to center, above and below
   assign row_c = y_ff[0] ? bank_rd0[1] : bank_rd0[0];
   assign row_u = y_ff[0] ? bank_rd0[0] : bank_rd0[1];
   assign row_d = y_ff[0] ? bank_rd1[0] : bank_rd1[1];

   // Effective image size
   assign eff_w = (EX'(width_ff) > EX'(MAX_WIDTH)) ? EX'(MAX_WIDTH) : EX'(width_ff);
   assign eff_h = (EY'(height_ff) > EY'(MAX_HEIGHT)) ? EY'(MAX_HEIGHT) : EY'(height_ff);

   // Neighbour bits, each dropped when it lies outside the image
   assign xc = CX'(x_ff);
   assign xl = xc - CX'(1);
   assign xr = xc + CX'(1);
   assign yc = CY'(y_ff);
   assign yd = yc + CY'(1);

   assign in_img = (EX'(xc) < eff_w) && (EY'(yc) < eff_h);
   assign has_l  = (x_ff != 8'd0);
   assign has_t  = (y_ff != 8'd0);
   assign has_r  = (EX'(xr) < eff_w);
   assign has_b  = (EY'(yd) < eff_h);

   assign bit_l = has_l && row_c[xl[XW-1:0]];
   assign bit_r = has_r && row_c[xr[XW-1:0]];
   assign bit_t = has_t && row_u[xc[XW-1:0]];
   assign bit_b = has_b && row_d[xc[XW-1:0]];

   assign do_add = (func_ff == FUNC_ADD) && in_img;
   assign do_set = ((func_ff == FUNC_MARK) || (func_ff == FUNC_ADD)) && in_img;
   assign q      = do_add ? (3'(bit_l) + 3'(bit_t) + 3'(bit_r) + 3'(bit_b)) : 3'd0;

   // Add 4 - 2q and clamp to the 24-bit range
   assign delta = 4'd4 - {q, 1'b0};
   assign sum   = 25'($signed(per_ff)) + 25'($signed(delta));
   always_comb begin
      case (sum[24:23])
         2'b01:   sat = PER_MAX;
         2'b10:   sat = PER_MIN;
         default: sat = sum[23:0];
      endcase
   end

   // Update the perimeter when the result is loaded
   always_comb begin
      per_in = per_ff;
      if (rsp_load) begin
         case (func_ff)
            FUNC_LOAD: per_in = start_ff;
            FUNC_ADD:  per_in = do_add ? sat : per_ff;
            default:   per_in = per_ff;
         endcase
      end
   end

   // Result register: load from busy, drop when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_per_in   = rsp_per_ff;
      rsp_q_in     = rsp_q_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_per_in   = per_in;
         rsp_q_in     = q;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_q_ff, rsp_per_ff};

   // Register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[8:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[8:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_IMAGE_HEIGHT) ? {23'd0, height_ff}
                                                          : {23'd0, width_ff};
   assign csr_pready = 1'b1;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         width_ff     <= IMAGE_SIZE_RESET;
         height_ff    <= IMAGE_SIZE_RESET;
         per_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         per_ff       <= per_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold the item while it is at work, and the result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_tuser;
         x_ff     <= req_tdata[7:0];
         y_ff     <= req_tdata[15:8];
         start_ff <= req_tdata[39:16];
      end
      rsp_per_ff <= rsp_per_in;
      rsp_q_ff   <= rsp_q_in;
   end

   `IRP_ASSERT_NEXT(a_accept_to_busy, clock, reset, accept, state_ff == ST_BUSY,
                    "accepted item did not enter busy")
   `IRP_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid),
                   $past(state_ff) == ST_BUSY, "result beat appeared without a busy cycle")
   `IRP_ASSERT_NOW(a_one_bank_set, clock, reset, bank_set[0] || bank_set[1],
                   !(bank_set[0] && bank_set[1]) && !clr_en,
                   "bitmap set hit both banks or the clear pass")
   `IRP_ASSERT_NEXT(a_stall_holds_item, clock, reset, (state_ff == ST_BUSY) && !rsp_load,
                    $stable(x_ff) && $stable(y_ff) && $stable(func_ff),
                    "item changed while waiting on the result register")

endmodule
`default_nettype wire

@@ sv/irp_row_bank.sv @@
// One bank of bitmap rows: two registered read ports, one bit-set/row-clear write port.
`timescale 1ns / 1ps
`default_nettype none
module irp_row_bank #(
   parameter int WORD_W = 256,
   parameter int ADDR_W = 7
) (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr0,
   input  wire logic [ADDR_W-1:0]         rd_addr1,
   output logic      [WORD_W-1:0]         rd_data0,
   output logic      [WORD_W-1:0]         rd_data1,
   input  wire logic                      clr_en,
   input  wire logic                      set_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [$clog2(WORD_W)-1:0] wr_bit
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [WORD_W-1:0] row_mem [DEPTH];
   logic [WORD_W-1:0] rd_data0_ff;
   logic [WORD_W-1:0] rd_data1_ff;

   // Clear a whole row, or set one bit of a row
   always_ff @(posedge clock) begin
      if (clr_en) begin
         row_mem[wr_addr] <= '0;
      end else if (set_en) begin
         row_mem[wr_addr][wr_bit] <= 1'b1;
      end
   end

   // Read two rows; hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= row_mem[rd_addr0];
         rd_data1_ff <= row_mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule
`default_nettype wire
